// ===== rtl/rpn_pkg.sv =====
// shared types and constants of the rpn stack evaluator
package rpn_pkg;

    // operand stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // fixed field widths
    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 5;

    typedef logic [2:0]               t_cmd;
    typedef logic [2:0]               t_status;
    typedef logic [3:0]               t_digit;
    typedef logic signed [DATA_W-1:0] t_value;
    typedef logic [DEPTH_W-1:0]       t_depth;

    // token codes
    localparam t_cmd CMD_PUSH   = 3'd0;
    localparam t_cmd CMD_ADD    = 3'd1;
    localparam t_cmd CMD_SUB    = 3'd2;
    localparam t_cmd CMD_MUL    = 3'd3;
    localparam t_cmd CMD_DIV    = 3'd4;
    localparam t_cmd CMD_EQUALS = 3'd5;
    localparam t_cmd CMD_ABORT  = 3'd6;

    // status codes
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_UNDERFLOW = 3'd1;
    localparam t_status ST_OVERFLOW  = 3'd2;
    localparam t_status ST_DIVZERO   = 3'd3;
    localparam t_status ST_TOOMANY   = 3'd4;

endpackage

// ===== rtl/rpn_if.sv =====
// token and result channel interfaces
interface rpn_tok_if;
    logic              valid;
    logic              ready;
    rpn_pkg::t_cmd     cmd;
    rpn_pkg::t_digit   digit;

    modport source (output valid, output cmd, output digit, input ready);
    modport sink   (input valid, input cmd, input digit, output ready);
endinterface

interface rpn_res_if;
    logic              valid;
    logic              ready;
    rpn_pkg::t_value   value;
    rpn_pkg::t_status  status;
    logic              done_res;
    rpn_pkg::t_depth   depth;

    modport source (output valid, output value, output status, output done_res,
                    output depth, input ready);
    modport sink   (input valid, input value, input status, input done_res,
                    input depth, output ready);
endinterface

// ===== rtl/rpn_divider.sv =====
// iterative signed divider, truncating toward zero, one quotient bit per cycle
module rpn_divider (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  rpn_pkg::t_value       i_dividend,
    input  rpn_pkg::t_value       i_divisor,
    output logic                  o_done,
    output rpn_pkg::t_value       o_quotient
);

    localparam int W     = rpn_pkg::DATA_W;
    localparam int STEPW = $clog2(W);

    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_div;
    logic [STEPW-1:0] r_step;
    logic             r_neg;
    logic             r_busy;
    logic             r_done;

    logic [W:0]       rem_sh;
    logic [W:0]       diff;

    // shift-subtract step
    assign rem_sh = {r_rem, r_quo[W-1]};
    assign diff   = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEPW'(W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // operand magnitudes and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[W-1] ^ i_divisor[W-1];
            r_quo <= i_dividend[W-1] ? W'(-i_dividend) : W'(i_dividend);
            r_div <= i_divisor[W-1] ? W'(-i_divisor) : W'(i_divisor);
            r_rem <= '0;
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? rpn_pkg::t_value'(-r_quo) : rpn_pkg::t_value'(r_quo);

endmodule

// ===== rtl/rpn_stack_evaluator.sv =====
// top level of the rpn stack evaluator: control, operand stack memory, result register
//
// Evaluates reverse Polish tokens one at a time on a stack of 32-bit signed
// values held in a single-port-read, single-port-write memory with a registered
// read port; the stack count lives in a register. One token is in work at a
// time and every token gives exactly one result beat. A push, an abort or any
// token that fails its depth check goes straight to the output state, equals
// reads the stack once, add, subtract and multiply take two memory reads, the
// operation and the write-back, and divide runs the 32-step shift-subtract
// divider between its reads and the write-back unless the divisor is zero. A
// new token is taken while the previous result still waits in the output register;
// the block stalls only when a second result is ready before the first has left.
module rpn_stack_evaluator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rpn_tok_if.sink       i_tok,
    rpn_res_if.source     o_res
);

    localparam int DEPTH = rpn_pkg::STACK_DEPTH;
    localparam int AW    = rpn_pkg::ADDR_W;
    localparam int CW    = rpn_pkg::CNT_W;
    localparam int W     = rpn_pkg::DATA_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_DIV,
        S_WB,
        S_OUT
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    rpn_pkg::t_cmd     r_cmd;
    logic [W-1:0]      r_right;
    logic [W-1:0]      r_res;
    rpn_pkg::t_status  r_status;
    logic              r_done;

    logic              r_out_valid;
    rpn_pkg::t_value   r_out_value;
    rpn_pkg::t_status  r_out_status;
    logic              r_out_done;
    rpn_pkg::t_depth   r_out_depth;

    // stack memory
    logic [W-1:0]      mem [DEPTH];
    logic [W-1:0]      r_rdata;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [W-1:0]      mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    logic              tok_acc;
    logic              is_arith;
    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     cnt_m2;
    logic              out_free;

    logic              div_start;
    logic              div_done;
    rpn_pkg::t_value   div_q;

    assign i_tok.ready = (r_state == S_IDLE);
    assign tok_acc     = i_tok.valid && i_tok.ready;
    assign is_arith    = (i_tok.cmd == rpn_pkg::CMD_ADD) || (i_tok.cmd == rpn_pkg::CMD_SUB)
                      || (i_tok.cmd == rpn_pkg::CMD_MUL) || (i_tok.cmd == rpn_pkg::CMD_DIV);
    assign cnt_m1      = r_count - 1'b1;
    assign cnt_m2      = r_count - CW'(2);
    assign out_free    = !r_out_valid || o_res.ready;
    assign div_start   = (r_state == S_RD2) && (r_cmd == rpn_pkg::CMD_DIV) && (r_right != '0);

    // memory access control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cnt_m2[AW-1:0];
        mem_wdata = r_res;
        mem_re    = 1'b0;
        mem_raddr = cnt_m1[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (tok_acc) begin
                    if (i_tok.cmd == rpn_pkg::CMD_PUSH) begin
                        mem_we    = (r_count < CW'(DEPTH));
                        mem_waddr = r_count[AW-1:0];
                        mem_wdata = W'(i_tok.digit);
                    end else if (is_arith) begin
                        mem_re = (r_count >= CW'(2));
                    end else if (i_tok.cmd == rpn_pkg::CMD_EQUALS) begin
                        mem_re = (r_count == CW'(1));
                    end
                end
            end
            S_RD1: begin
                mem_re    = (r_cmd != rpn_pkg::CMD_EQUALS);
                mem_raddr = cnt_m2[AW-1:0];
            end
            S_WB: begin
                mem_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    rpn_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (rpn_pkg::t_value'(r_rdata)),
        .i_divisor  (rpn_pkg::t_value'(r_right)),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // sequencer, stack count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (tok_acc) begin
                        r_cmd <= i_tok.cmd;
                        if (i_tok.cmd == rpn_pkg::CMD_PUSH) begin
                            r_state <= S_OUT;
                            if (r_count >= CW'(DEPTH)) begin
                                r_count  <= '0;
                                r_res    <= '0;
                                r_status <= rpn_pkg::ST_OVERFLOW;
                                r_done   <= 1'b1;
                            end else begin
                                r_count  <= r_count + 1'b1;
                                r_res    <= W'(i_tok.digit);
                                r_status <= rpn_pkg::ST_OK;
                                r_done   <= 1'b0;
                            end
                        end else if (is_arith) begin
                            r_res <= '0;
                            if (r_count < CW'(2)) begin
                                r_count  <= '0;
                                r_status <= rpn_pkg::ST_UNDERFLOW;
                                r_done   <= 1'b1;
                                r_state  <= S_OUT;
                            end else begin
                                r_status <= rpn_pkg::ST_OK;
                                r_done   <= 1'b0;
                                r_state  <= S_RD1;
                            end
                        end else if (i_tok.cmd == rpn_pkg::CMD_EQUALS) begin
                            r_res  <= '0;
                            r_done <= 1'b1;
                            if (r_count == '0) begin
                                r_status <= rpn_pkg::ST_UNDERFLOW;
                                r_state  <= S_OUT;
                            end else if (r_count > CW'(1)) begin
                                r_count  <= '0;
                                r_status <= rpn_pkg::ST_TOOMANY;
                                r_state  <= S_OUT;
                            end else begin
                                r_status <= rpn_pkg::ST_OK;
                                r_state  <= S_RD1;
                            end
                        end else begin
                            // abort and the spare code
                            r_count  <= '0;
                            r_res    <= '0;
                            r_status <= rpn_pkg::ST_OK;
                            r_done   <= 1'b1;
                            r_state  <= S_OUT;
                        end
                    end
                end
                S_RD1: begin
                    if (r_cmd == rpn_pkg::CMD_EQUALS) begin
                        r_res   <= r_rdata;
                        r_count <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_right <= r_rdata;
                        r_state <= S_RD2;
                    end
                end
                S_RD2: begin
                    // left operand is in the read register now
                    case (r_cmd)
                        rpn_pkg::CMD_ADD: begin
                            r_res   <= r_rdata + r_right;
                            r_state <= S_WB;
                        end
                        rpn_pkg::CMD_SUB: begin
                            r_res   <= r_rdata - r_right;
                            r_state <= S_WB;
                        end
                        rpn_pkg::CMD_MUL: begin
                            r_res   <= W'(r_rdata * r_right);
                            r_state <= S_WB;
                        end
                        default: begin
                            if (r_right == '0) begin
                                r_count  <= '0;
                                r_status <= rpn_pkg::ST_DIVZERO;
                                r_done   <= 1'b1;
                                r_state  <= S_OUT;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                    endcase
                end
                S_DIV: begin
                    if (div_done) begin
                        r_res   <= W'(div_q);
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_count <= cnt_m1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_value  <= rpn_pkg::t_value'(r_res);
                        r_out_status <= r_status;
                        r_out_done   <= r_done;
                        r_out_depth  <= rpn_pkg::t_depth'(r_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.value    = r_out_value;
    assign o_res.status   = r_out_status;
    assign o_res.done_res = r_out_done;
    assign o_res.depth    = r_out_depth;

endmodule
